[hw/rtl/pot_ema_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pot_ema_pkg
// Shared types and constants for the oversampled EMA filter with hysteresis.
// ----------------------------------------------------------------------------
package pot_ema_pkg;

    localparam int CHANNELS            = 8;
    localparam int SAMPLES_PER_AVERAGE = 16;

    localparam int CH_W     = 3;
    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = 16;
    localparam int CNT_W    = 4;
    localparam int AVG_W    = 24;
    localparam int FRAC_W   = 8;
    localparam int LEVEL_W  = 16;
    localparam int WEIGHT_W = 8;
    localparam int THRESH_W = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    // count value that closes an averaging block (count wraps modulo 16)
    localparam logic [CNT_W-1:0] BLOCK_END = CNT_W'(SAMPLES_PER_AVERAGE % 16);

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd26;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd328;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0]     channel;
        logic [SAMPLE_W-1:0] sample;
    } in_t;

    typedef struct packed {
        logic [CH_W-1:0]    report_channel;
        logic [LEVEL_W-1:0] smoothed_level;
    } out_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] smoothing_weight;
        logic [THRESH_W-1:0] report_threshold;
    } cfg_t;

endpackage

[hw/rtl/pot_ema_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pot_ema_cfg
// Configuration registers: smoothing weight and report threshold.
// ----------------------------------------------------------------------------
module pot_ema_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [pot_ema_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pot_ema_pkg::CFG_W-1:0]   cfg_data,
    output pot_ema_pkg::cfg_t               cfg
);

    pot_ema_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.smoothing_weight <= pot_ema_pkg::WEIGHT_RESET;
            cfg_reg.report_threshold <= pot_ema_pkg::THRESH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pot_ema_pkg::REG_WEIGHT:
                    cfg_reg.smoothing_weight <= cfg_data[pot_ema_pkg::WEIGHT_W-1:0];
                pot_ema_pkg::REG_THRESHOLD:
                    cfg_reg.report_threshold <= cfg_data[pot_ema_pkg::THRESH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/pot_ema_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pot_ema_core
// Input register, per-channel state and the single-pass EMA/hysteresis update.
// ----------------------------------------------------------------------------
module pot_ema_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pot_ema_pkg::in_t   in_req,
    input  pot_ema_pkg::cfg_t  cfg,
    output logic               res_valid,
    input  logic               res_ready,
    output pot_ema_pkg::out_t  res
);

    logic                                s1_valid_reg;
    pot_ema_pkg::in_t                    s1_req_reg;

    logic [pot_ema_pkg::SUM_W-1:0]       sum_reg   [pot_ema_pkg::CHANNELS];
    logic [pot_ema_pkg::CNT_W-1:0]       cnt_reg   [pot_ema_pkg::CHANNELS];
    logic [pot_ema_pkg::AVG_W-1:0]       avg_reg   [pot_ema_pkg::CHANNELS];
    logic [pot_ema_pkg::LEVEL_W-1:0]     last_reg  [pot_ema_pkg::CHANNELS];
    logic [pot_ema_pkg::CHANNELS-1:0]    never_reg;

    logic [pot_ema_pkg::CH_W-1:0]        ch;
    logic                                in_range;
    logic [pot_ema_pkg::SUM_W-1:0]       sum_add;
    logic [pot_ema_pkg::CNT_W-1:0]       cnt_inc;
    logic                                done;
    logic signed [24:0]                  diff;
    logic signed [8:0]                   weight_s;
    logic signed [33:0]                  prod;
    logic signed [33:0]                  rounded;
    logic signed [25:0]                  step;
    logic signed [26:0]                  avg_sum;
    logic [pot_ema_pkg::AVG_W-1:0]       avg_new;
    logic [pot_ema_pkg::LEVEL_W-1:0]     level;
    logic [pot_ema_pkg::LEVEL_W-1:0]     last;
    logic [pot_ema_pkg::LEVEL_W-1:0]     delta;
    logic                                report;
    logic                                advance;
    logic                                fire;

    assign ch       = s1_req_reg.channel;
    assign in_range = (32'(ch) < pot_ema_pkg::CHANNELS);

    always_comb
    begin
        sum_add  = sum_reg[ch] + pot_ema_pkg::SUM_W'(s1_req_reg.sample);
        cnt_inc  = cnt_reg[ch] + 4'd1;
        done     = (cnt_inc == pot_ema_pkg::BLOCK_END);

        diff     = $signed({1'b0, sum_add, 8'h00}) - $signed({1'b0, avg_reg[ch]});
        weight_s = $signed({1'b0, cfg.smoothing_weight});
        prod     = diff * weight_s;
        // floor((diff*w + 128) / 256)
        rounded  = prod + 34'sd128;
        step     = rounded[33:8];
        avg_sum  = $signed({3'b000, avg_reg[ch]}) + $signed({step[25], step});

        if (avg_sum < 27'sd0)
            avg_new = '0;
        else if (avg_sum > $signed({3'b000, {pot_ema_pkg::AVG_W{1'b1}}}))
            avg_new = {pot_ema_pkg::AVG_W{1'b1}};
        else
            avg_new = avg_sum[pot_ema_pkg::AVG_W-1:0];

        level = avg_new[pot_ema_pkg::AVG_W-1:pot_ema_pkg::FRAC_W];
        last  = last_reg[ch];
        delta = (level > last) ? (level - last) : (last - level);

        report = in_range && done && (never_reg[ch] || (delta > cfg.report_threshold));
    end

    assign advance  = !report || res_ready;
    assign fire     = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_req_reg <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pot_ema_pkg::CHANNELS; i++)
            begin
                sum_reg[i]  <= '0;
                cnt_reg[i]  <= '0;
                avg_reg[i]  <= '0;
                last_reg[i] <= '0;
            end
            never_reg <= '1;
        end
        else if (fire && in_range)
        begin
            if (done)
            begin
                sum_reg[ch] <= '0;
                cnt_reg[ch] <= '0;
                avg_reg[ch] <= avg_new;
            end
            else
            begin
                sum_reg[ch] <= sum_add;
                cnt_reg[ch] <= cnt_inc;
            end
            if (report)
            begin
                last_reg[ch]  <= level;
                never_reg[ch] <= 1'b0;
            end
        end
    end

    assign res_valid          = s1_valid_reg && report;
    assign res.report_channel = ch;
    assign res.smoothed_level = level;

endmodule

[hw/rtl/pot_ema_out.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pot_ema_out
// Result register: holds one report until the receiver takes it.
// ----------------------------------------------------------------------------
module pot_ema_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_valid,
    output logic               res_ready,
    input  pot_ema_pkg::out_t  res,
    output logic               out_valid,
    input  logic               out_ready,
    output pot_ema_pkg::out_t  out_req
);

    logic              valid_reg;
    pot_ema_pkg::out_t data_reg;

    assign res_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_req   = data_reg;

endmodule

[hw/rtl/pot_oversample_ema_hysteresis_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pot_oversample_ema_hysteresis_top
// Per-channel oversampling, EMA smoothing and change-triggered reporting.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_req): one 12-bit sample with its channel
// number. Output channel (out_valid/out_ready/out_req): a channel number and
// its new smoothed level, sent only when the level moved by more than the
// threshold or the channel has not reported yet.
// Config port: cfg_write with cfg_index 0 sets the smoothing weight,
// index 1 the report threshold. Write only while the block is idle.
// Throughput: one sample per cycle while in_ready is high. An accepted sample
// enters the input register; the per-channel read-modify-write and the weight
// multiply run while it is held there, and a report then moves on into the
// output register, from which the receiver takes it.
// When the receiver stalls, a pending report holds the output register; one
// more sample can wait in the input register, and samples that do not report
// keep flowing through. in_ready drops only when a reporting sample is
// blocked behind a held report.
// Reset clears all channel sums, counts, averages and reported levels, marks
// every channel as not yet reported and loads the default weight/threshold.
// ----------------------------------------------------------------------------
module pot_oversample_ema_hysteresis_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  pot_ema_pkg::in_t                  in_req,
    output logic                              out_valid,
    input  logic                              out_ready,
    output pot_ema_pkg::out_t                 out_req,
    input  logic                              cfg_write,
    input  logic [pot_ema_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pot_ema_pkg::CFG_W-1:0]     cfg_data
);

    pot_ema_pkg::cfg_t cfg;
    pot_ema_pkg::out_t res;
    logic              res_valid;
    logic              res_ready;

    pot_ema_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pot_ema_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_req    (in_req),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    pot_ema_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_req   (out_req)
    );

endmodule

[hw/rtl/pot_ema_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pot_ema_checker
// Port-level checks for the EMA hysteresis block, bound to the top level.
// ----------------------------------------------------------------------------
module pot_ema_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              out_valid,
    input  logic              out_ready,
    input  pot_ema_pkg::out_t out_req
);

    // a held report does not change under stall
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_req))
        else $error("report changed while stalled");

    // with an empty output register nothing can block the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    // reports only name configured channels
    a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(out_req.report_channel) < pot_ema_pkg::CHANNELS))
        else $error("report on channel out of range");

    // no report can appear without a request having entered earlier
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid, 2) || $past(in_valid))
        else $error("report without a preceding request");

endmodule

bind pot_oversample_ema_hysteresis_top pot_ema_checker u_pot_ema_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_req   (out_req)
);

[tb/sv/pot_oversample_ema_hysteresis_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pot_oversample_ema_hysteresis_top_test
// Self-checking bench for the per-channel oversampling EMA filter with
// change-triggered reporting. Samples are queued by a stimulus process and
// presented by a clocked driver, which also runs a bit-accurate model of the
// sums, averages and report hysteresis on every accepted request. A clocked
// monitor compares each report against the oldest predicted one. The run
// steps through several weight/threshold settings, extremes included, under
// mixes of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module pot_oversample_ema_hysteresis_top_test;

    import pot_ema_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int SAMPLE_TARGET = 950;
    localparam int PHASE_SAMPLES = 110;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_t                  in_req    = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_t                 out_req;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_WEIGHT;
    logic [CFG_W-1:0]     cfg_data  = '0;

    pot_oversample_ema_hysteresis_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_req   (out_req),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // filter model state
    logic [WEIGHT_W-1:0] cur_weight;
    logic [THRESH_W-1:0] cur_threshold;
    logic [SUM_W-1:0]    block_sum   [CHANNELS];
    logic [CNT_W-1:0]    block_count [CHANNELS];
    logic [AVG_W-1:0]    ema_level   [CHANNELS];
    logic [LEVEL_W-1:0]  sent_level  [CHANNELS];
    logic                first_pending [CHANNELS];

    in_t  sample_queue[$];
    out_t expected_reports[$];
    out_t want;

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int samples_queued  = 0;
    int samples_taken   = 0;
    int reports_checked = 0;
    int settings_run    = 0;
    int error_count     = 0;
    int cycle_count     = 0;
    int level_target [CHANNELS];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("pot_oversample_ema_hysteresis_top_test: errors");
            $finish;
        end
    end

    task automatic filter_sample(input in_t s);
        int                  ch;
        longint signed       diff;
        longint signed       next_avg;
        logic [LEVEL_W-1:0]  lvl;
        logic [LEVEL_W-1:0]  delta;
        out_t                rep;
        ch = int'(s.channel);
        if (ch >= CHANNELS)
            return;
        block_sum[ch]   = block_sum[ch] + SUM_W'(s.sample);
        block_count[ch] = block_count[ch] + 1'b1;
        if (block_count[ch] != BLOCK_END)
            return;
        diff     = longint'(block_sum[ch]) * 256 - longint'(ema_level[ch]);
        next_avg = longint'(ema_level[ch])
                 + ((diff * longint'(cur_weight) + 128) >>> 8);
        if (next_avg < 0)
            next_avg = 0;
        if (next_avg > longint'({AVG_W{1'b1}}))
            next_avg = longint'({AVG_W{1'b1}});
        ema_level[ch]   = AVG_W'(next_avg);
        block_sum[ch]   = '0;
        block_count[ch] = '0;
        lvl   = ema_level[ch][AVG_W-1:FRAC_W];
        delta = (lvl > sent_level[ch]) ? lvl - sent_level[ch] : sent_level[ch] - lvl;
        if (!first_pending[ch] && delta <= cur_threshold)
            return;
        sent_level[ch]    = lvl;
        first_pending[ch] = 1'b0;
        rep.report_channel = s.channel;
        rep.smoothed_level = lvl;
        expected_reports.push_back(rep);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_req   <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                filter_sample(in_req);
                samples_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (sample_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_req   <= sample_queue.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("unexpected report: report_channel %0d smoothed_level %0d",
                           out_req.report_channel, out_req.smoothed_level);
                    error_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (out_req.report_channel !== want.report_channel)
                    begin
                        $error("report_channel: expected %0d actual %0d",
                               want.report_channel, out_req.report_channel);
                        error_count++;
                    end
                    if (out_req.smoothed_level !== want.smoothed_level)
                    begin
                        $error("smoothed_level: expected %0d actual %0d",
                               want.smoothed_level, out_req.smoothed_level);
                        error_count++;
                    end
                    reports_checked++;
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic queue_sample(input int ch, input int smp);
        in_t s;
        s.channel = CH_W'(ch);
        s.sample  = SAMPLE_W'(smp);
        sample_queue.push_back(s);
        samples_queued++;
    endtask

    task automatic drain_block;
        do
            @(posedge clk);
        while (samples_taken != samples_queued || expected_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_WEIGHT)
            cur_weight = val[WEIGHT_W-1:0];
        else if (idx == REG_THRESHOLD)
            cur_threshold = val[THRESH_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        int                  phase;
        int                  ch;
        int                  focus;
        int                  smp;
        logic [WEIGHT_W-1:0] w;
        logic [THRESH_W-1:0] t;
        cur_weight    = WEIGHT_RESET;
        cur_threshold = THRESH_RESET;
        for (int i = 0; i < CHANNELS; i++)
        begin
            block_sum[i]     = '0;
            block_count[i]   = '0;
            ema_level[i]     = '0;
            sent_level[i]    = '0;
            first_pending[i] = 1'b1;
            level_target[i]  = 2048;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // channel 0 at zero gives a first report of level zero; channel 7 at full scale
        for (int i = 0; i < 16; i++)
        begin
            queue_sample(0, 0);
            if (i < 9)
                queue_sample(7, SAMPLE_MAX);
        end
        drain_block();

        phase = 0;
        while (samples_queued < SAMPLE_TARGET)
        begin
            case (phase)
                0: begin w = 8'd255;       t = 16'd0;     end
                1: begin w = 8'd0;         t = 16'd0;     end
                2: begin w = 8'd1;         t = 16'hFFFF;  end
                3: begin w = WEIGHT_RESET; t = THRESH_RESET; end
                default:
                begin
                    w = WEIGHT_W'($urandom_range(1, 255));
                    if ($urandom_range(0, 3) == 0)
                        t = THRESH_W'($urandom_range(0, 65535));
                    else
                        t = THRESH_W'($urandom_range(0, 600));
                end
            endcase
            write_reg(REG_WEIGHT, CFG_W'(w));
            write_reg(REG_THRESHOLD, CFG_W'(t));
            case (phase % 4)
                0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct <= 50; recv_stall_pct <= 0;  end
                2: begin send_idle_pct <= 0;  recv_stall_pct <= 50; end
                default: begin send_idle_pct <= 28; recv_stall_pct <= 28; end
            endcase
            settings_run++;

            focus = $urandom_range(0, CHANNELS - 1);
            for (int i = 0; i < PHASE_SAMPLES; i++)
            begin
                if ($urandom_range(0, 1) == 0)
                    ch = focus;
                else
                    ch = $urandom_range(0, CHANNELS - 1);
                if ($urandom_range(0, 9) == 0)
                    level_target[ch] = $urandom_range(0, 4095);
                case ($urandom_range(0, 9))
                    0: smp = ($urandom_range(0, 1) == 0) ? 0 : 4095;
                    1: smp = $urandom_range(0, 4095);
                    default:
                    begin
                        smp = level_target[ch] + $urandom_range(0, 40) - 20;
                        if (smp < 0)
                            smp = 0;
                        if (smp > 4095)
                            smp = 4095;
                    end
                endcase
                queue_sample(ch, smp);
            end
            drain_block();
            phase++;
        end

        $display("Covered %0d samples over %0d filter settings (weight 0/1/255, threshold 0/max).",
                 samples_taken, settings_run);
        $display("Checked %0d reports under idle-free, sender-idle, receiver-stall and mixed traffic.",
                 reports_checked);
        if (error_count == 0)
            $display("pot_oversample_ema_hysteresis_top_test: clean");
        else
            $display("pot_oversample_ema_hysteresis_top_test: errors");
        $finish;
    end

endmodule
